/* sv/bffl_pkg.sv */
// Shared constants and types for the binary fuse filter lookup unit.
`default_nettype none
package bffl_pkg;

  localparam int TABLE_DEPTH    = 65536;
  localparam int SEG_SLOTS      = 8;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int SEG_W          = $clog2(SEG_SLOTS);
  localparam int IDX_W          = 14 + SEG_W;
  localparam int CMP_W          = 32;

  localparam int QUEUE_DEPTH = 16;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int OUT_DEPTH   = 4;
  localparam int OPTR_W      = $clog2(OUT_DEPTH);
  localparam int OCNT_W      = $clog2(OUT_DEPTH + 1) + 1;

  localparam logic [63:0] MUL_A     = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] MUL_B     = 64'h165667B19E3779F9;
  localparam logic [63:0] FP_OFFSET = 64'h9E3779B97F4A7C15;

  localparam int CFG_W     = 64;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEG_TOTAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LEN = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE_FP   = 2'd3;

  localparam logic OP_QUERY = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef struct packed {
    logic [63:0] seed;
    logic [63:0] seed_fp;
    logic [12:0] seg_total;
    logic [16:0] table_len;
    logic        wide;
  } cfg_t;

  // one queued operation: three slot reads for a query, one store for a write
  typedef struct packed {
    logic              opcode;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [2:0]        use_slot;
    logic [15:0]       fp;
  } qent_t;

endpackage
`default_nettype wire

/* sv/bffl_req_if.sv */
// Request channel: query or table write items into the lookup unit.
`default_nettype none
interface bffl_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] key;
  logic [15:0] slot;
  logic [15:0] entry_value;

  modport source (output valid, opcode, key, slot, entry_value, input ready);
  modport sink (input valid, opcode, key, slot, entry_value, output ready);
endinterface
`default_nettype wire

/* sv/bffl_rsp_if.sv */
// Response channel: membership results and write acknowledgements.
`default_nettype none
interface bffl_rsp_if;
  logic valid;
  logic ready;
  logic is_member;
  logic query_done;

  modport source (output valid, is_member, query_done, input ready);
  modport sink (input valid, is_member, query_done, output ready);
endinterface
`default_nettype wire

/* sv/bffl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bffl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* sv/bffl_front.sv */
// Front end: request intake, two-way key hashing pipeline and slot index forming.
`default_nettype none
module bffl_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire bffl_pkg::cfg_t cfg,
  bffl_req_if.sink           req,
  input  wire logic          q_pop,
  output logic               push,
  output bffl_pkg::qent_t    push_entry
);

  logic [bffl_pkg::QCNT_W-1:0] credit;
  logic                        accept;

  logic [6:0]  vld;
  logic        op_line   [6];
  logic [15:0] slot_line [6];
  logic [15:0] val_line  [6];

  logic [63:0] x0   [2];
  logic [63:0] a1   [2];
  logic [63:0] pa_lo[2];
  logic [31:0] pa_m1[2];
  logic [31:0] pa_m2[2];
  logic [63:0] y2   [2];
  logic [63:0] b3   [2];
  logic [63:0] pb_lo[2];
  logic [31:0] pb_m1[2];
  logic [31:0] pb_m2[2];
  logic [63:0] z4   [2];
  logic [63:0] h4   [2];
  logic [44:0] segprod5;
  logic [63:0] h5;
  logic [15:0] fp5;

  logic [12:0]                 seg;
  logic [13:0]                 seg1;
  logic [13:0]                 seg2;
  logic [bffl_pkg::IDX_W-1:0]  idx0;
  logic [bffl_pkg::IDX_W-1:0]  idx1;
  logic [bffl_pkg::IDX_W-1:0]  idx2;
  logic [bffl_pkg::CMP_W-1:0]  idx0_ext;
  logic [bffl_pkg::CMP_W-1:0]  idx1_ext;
  logic [bffl_pkg::CMP_W-1:0]  idx2_ext;
  logic [bffl_pkg::CMP_W-1:0]  slot_ext;
  logic [bffl_pkg::CMP_W-1:0]  len_ext;
  logic [bffl_pkg::CMP_W-1:0]  depth_ext;
  bffl_pkg::qent_t             ent_next;
  bffl_pkg::qent_t             ent6;

  // credit covers every item in the pipeline plus the queue
  assign req.ready = credit < bffl_pkg::QCNT_W'(bffl_pkg::QUEUE_DEPTH);
  assign accept    = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      credit <= '0;
      vld    <= '0;
    end else begin
      credit <= credit + bffl_pkg::QCNT_W'(accept) - bffl_pkg::QCNT_W'(q_pop);
      vld    <= {vld[5:0], accept};
    end
  end

  always_ff @(posedge clk) begin
    op_line[0]   <= req.opcode;
    slot_line[0] <= req.slot;
    val_line[0]  <= req.entry_value;
    for (int i = 1; i < 6; i++) begin
      op_line[i]   <= op_line[i-1];
      slot_line[i] <= slot_line[i-1];
      val_line[i]  <= val_line[i-1];
    end
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      a1[j] = x0[j] ^ (x0[j] >> 33);
      b3[j] = y2[j] ^ (y2[j] >> 29);
    end
  end

  // 64-bit products split into 32x32 partial products, summed a stage later
  always_ff @(posedge clk) begin
    x0[0] <= req.key ^ cfg.seed;
    x0[1] <= req.key ^ cfg.seed_fp;
    for (int j = 0; j < 2; j++) begin
      pa_lo[j] <= a1[j][31:0] * bffl_pkg::MUL_A[31:0];
      pa_m1[j] <= a1[j][31:0] * bffl_pkg::MUL_A[63:32];
      pa_m2[j] <= a1[j][63:32] * bffl_pkg::MUL_A[31:0];
      y2[j]    <= pa_lo[j] + {pa_m1[j] + pa_m2[j], 32'b0};
      pb_lo[j] <= b3[j][31:0] * bffl_pkg::MUL_B[31:0];
      pb_m1[j] <= b3[j][31:0] * bffl_pkg::MUL_B[63:32];
      pb_m2[j] <= b3[j][63:32] * bffl_pkg::MUL_B[31:0];
      h4[j]    <= z4[j] ^ (z4[j] >> 32);
    end
    segprod5 <= h4[0][63:32] * cfg.seg_total;
    h5       <= h4[0];
    fp5      <= cfg.wide ? h4[1][63:48] : {8'b0, h4[1][7:0]};
    ent6     <= ent_next;
  end

  always_comb begin
    for (int j = 0; j < 2; j++) begin
      z4[j] = pb_lo[j] + {pb_m1[j] + pb_m2[j], 32'b0};
    end
  end

  always_comb begin
    seg       = segprod5[44:32];
    seg1      = {1'b0, seg} + 14'd1;
    seg2      = {1'b0, seg} + 14'd2;
    idx0      = {1'b0, seg, h5[bffl_pkg::SEG_W-1:0]};
    idx1      = {seg1, h5[16 +: bffl_pkg::SEG_W]};
    idx2      = {seg2, h5[48 +: bffl_pkg::SEG_W]};
    idx0_ext  = bffl_pkg::CMP_W'(idx0);
    idx1_ext  = bffl_pkg::CMP_W'(idx1);
    idx2_ext  = bffl_pkg::CMP_W'(idx2);
    slot_ext  = bffl_pkg::CMP_W'(slot_line[5]);
    len_ext   = bffl_pkg::CMP_W'(cfg.table_len);
    depth_ext = bffl_pkg::CMP_W'(bffl_pkg::TABLE_DEPTH);

    ent_next.opcode = op_line[5];
    if (op_line[5] == bffl_pkg::OP_WRITE) begin
      ent_next.addr0    = slot_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.addr1    = slot_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.addr2    = slot_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.use_slot = {2'b0, slot_ext < depth_ext};
      ent_next.fp       = val_line[5];
    end else begin
      ent_next.addr0    = idx0_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.addr1    = idx1_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.addr2    = idx2_ext[bffl_pkg::ADDR_W-1:0];
      ent_next.use_slot = {(idx2_ext < len_ext) && (idx2_ext < depth_ext),
                           (idx1_ext < len_ext) && (idx1_ext < depth_ext),
                           (idx0_ext < len_ext) && (idx0_ext < depth_ext)};
      ent_next.fp       = fp5;
    end
  end

  assign push       = vld[6];
  assign push_entry = ent6;

endmodule
`default_nettype wire

/* sv/bffl_queue.sv */
// Operation queue between the hashing front end and the table back end.
`default_nettype none
module bffl_queue (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  input  wire bffl_pkg::qent_t             push_entry,
  input  wire logic                        pop,
  output logic                             not_empty,
  output bffl_pkg::qent_t                  head,
  output logic [bffl_pkg::QCNT_W-1:0]      count
);

  bffl_pkg::qent_t               entries [bffl_pkg::QUEUE_DEPTH];
  logic [bffl_pkg::QPTR_W-1:0]   wr_ptr;
  logic [bffl_pkg::QPTR_W-1:0]   rd_ptr;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + bffl_pkg::QCNT_W'(push) - bffl_pkg::QCNT_W'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  assign not_empty = count != '0;
  assign head      = entries[rd_ptr];

endmodule
`default_nettype wire

/* sv/bffl_back.sv */
// Back end: table stores, three-slot XOR, fingerprint compare and response buffer.
`default_nettype none
module bffl_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            wide,
  input  wire logic            q_valid,
  input  wire bffl_pkg::qent_t q_head,
  output logic                 q_pop,
  bffl_rsp_if.source           rsp
);

  logic                        issue;
  logic                        table_we;
  logic [15:0]                 rd0;
  logic [15:0]                 rd1;
  logic [15:0]                 rd2;

  logic                        b1_valid;
  logic                        b1_op;
  logic [2:0]                  b1_use;
  logic [15:0]                 b1_fp;

  logic [15:0]                 x;
  logic                        hit;
  logic                        res_member;
  logic                        res_done;

  logic                        member_q [bffl_pkg::OUT_DEPTH];
  logic                        done_q   [bffl_pkg::OUT_DEPTH];
  logic [bffl_pkg::OPTR_W-1:0] wr_ptr;
  logic [bffl_pkg::OPTR_W-1:0] rd_ptr;
  logic [bffl_pkg::OCNT_W-1:0] out_count;
  logic                        out_pop;

  // issue only when the response buffer has room for everything in flight
  assign issue = q_valid &&
                 ((out_count + bffl_pkg::OCNT_W'(b1_valid)) <
                  bffl_pkg::OCNT_W'(bffl_pkg::OUT_DEPTH));
  assign q_pop    = issue;
  assign table_we = issue && (q_head.opcode == bffl_pkg::OP_WRITE) && q_head.use_slot[0];

  // one copy of the table per slot read
  bffl_ram #(.WIDTH(16), .DEPTH(bffl_pkg::TABLE_DEPTH)) u_ram0 (
    .clk(clk), .we(table_we), .waddr(q_head.addr0), .wdata(q_head.fp),
    .raddr(q_head.addr0), .rdata(rd0)
  );
  bffl_ram #(.WIDTH(16), .DEPTH(bffl_pkg::TABLE_DEPTH)) u_ram1 (
    .clk(clk), .we(table_we), .waddr(q_head.addr0), .wdata(q_head.fp),
    .raddr(q_head.addr1), .rdata(rd1)
  );
  bffl_ram #(.WIDTH(16), .DEPTH(bffl_pkg::TABLE_DEPTH)) u_ram2 (
    .clk(clk), .we(table_we), .waddr(q_head.addr0), .wdata(q_head.fp),
    .raddr(q_head.addr2), .rdata(rd2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
    end else begin
      b1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    b1_op  <= q_head.opcode;
    b1_use <= q_head.use_slot;
    b1_fp  <= q_head.fp;
  end

  always_comb begin
    x = (b1_use[0] ? rd0 : 16'd0) ^ (b1_use[1] ? rd1 : 16'd0) ^
        (b1_use[2] ? rd2 : 16'd0);
    hit        = wide ? (x == b1_fp) : (x[7:0] == b1_fp[7:0]);
    res_done   = b1_op == bffl_pkg::OP_QUERY;
    res_member = res_done && hit;
  end

  assign out_pop = rsp.valid && rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      out_count <= '0;
    end else begin
      if (b1_valid) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (out_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      out_count <= out_count + bffl_pkg::OCNT_W'(b1_valid) - bffl_pkg::OCNT_W'(out_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b1_valid) begin
      member_q[wr_ptr] <= res_member;
      done_q[wr_ptr]   <= res_done;
    end
  end

  assign rsp.valid      = out_count != '0;
  assign rsp.is_member  = member_q[rd_ptr];
  assign rsp.query_done = done_q[rd_ptr];

endmodule
`default_nettype wire

/* sv/binary_fuse_filter_lookup_unit.sv */
// Top level of the binary fuse filter lookup unit.
// Takes one request per cycle and returns exactly one response per request, in
// request order: a membership result for a query, an acknowledgement for a table
// write. A request goes through a seven-stage hashing pipeline (two 64-bit
// shift-xor-multiply mixes built from 32x32 partial products, then the
// segment reduction and slot index forming), waits in a 16-entry operation queue,
// reads its three slots in the same cycle from three copies of the table, and lands
// in a 4-entry response buffer. The input stalls only when responses back up far
// enough to fill the buffer, the queue and the pipeline. Writes update all three
// copies, so a query sees every write accepted before it. The table has no
// reset: write every slot below the table length before querying.
`default_nettype none
module binary_fuse_filter_lookup_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [bffl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [bffl_pkg::CFG_W-1:0]     cfg_data,
  bffl_req_if.sink                            req,
  bffl_rsp_if.source                          rsp
);

  bffl_pkg::cfg_t              cfg;
  logic                        push;
  bffl_pkg::qent_t             push_entry;
  logic                        q_pop;
  logic                        q_valid;
  bffl_pkg::qent_t             q_head;
  logic [bffl_pkg::QCNT_W-1:0] q_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seed      <= '0;
      cfg.seed_fp   <= bffl_pkg::FP_OFFSET;
      cfg.seg_total <= 13'd3;
      cfg.table_len <= '0;
      cfg.wide      <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bffl_pkg::REG_SEED: begin
          cfg.seed    <= cfg_data;
          cfg.seed_fp <= cfg_data + bffl_pkg::FP_OFFSET;
        end
        bffl_pkg::REG_SEG_TOTAL: cfg.seg_total <= cfg_data[12:0];
        bffl_pkg::REG_TABLE_LEN: cfg.table_len <= cfg_data[16:0];
        bffl_pkg::REG_WIDE_FP:   cfg.wide      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bffl_front u_front (
    .clk(clk), .rst(rst), .cfg(cfg), .req(req), .q_pop(q_pop),
    .push(push), .push_entry(push_entry)
  );

  bffl_queue u_queue (
    .clk(clk), .rst(rst), .push(push), .push_entry(push_entry), .pop(q_pop),
    .not_empty(q_valid), .head(q_head), .count(q_count)
  );

  bffl_back u_back (
    .clk(clk), .rst(rst), .wide(cfg.wide), .q_valid(q_valid), .q_head(q_head),
    .q_pop(q_pop), .rsp(rsp)
  );

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= bffl_pkg::QCNT_W'(bffl_pkg::QUEUE_DEPTH))
    else $error("operation queue overflow");

  a_ack_not_member: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && !rsp.query_done) |-> !rsp.is_member)
    else $error("write acknowledgement flagged as member");

  a_quiet_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (!rsp.valid && !q_valid))
    else $error("activity right after reset");

endmodule
`default_nettype wire

/* bench/binary_fuse_filter_lookup_unit_test.sv */
// Testbench for the binary fuse filter lookup unit: directed and random requests vs. a predictor.
`default_nettype none
module binary_fuse_filter_lookup_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          WORDS     = 65536;
  localparam logic [63:0] SEG_LEN   = 64'd8;
  localparam logic [63:0] SEG_MASK  = SEG_LEN - 64'd1;
  localparam logic [63:0] HASH_MUL1 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_MUL2 = 64'h165667B19E3779F9;
  localparam logic [63:0] FP_ADD    = 64'h9E3779B97F4A7C15;
  localparam int          LIMIT     = 1000000;

  typedef struct packed {
    logic is_member;
    logic query_done;
  } answer_t;

  typedef struct packed {
    logic [63:0] i0;
    logic [63:0] i1;
    logic [63:0] i2;
    logic [15:0] fp;
  } slots_t;

  typedef enum {FIX_NONE, FIX_HIT, FIX_NEAR} fix_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [bffl_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [bffl_pkg::CFG_W-1:0] cfg_data;

  bffl_req_if req ();
  bffl_rsp_if rsp ();

  binary_fuse_filter_lookup_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .rsp       (rsp)
  );

  // predictor state
  logic [63:0] cfg_seed;
  logic [12:0] cfg_segments;
  logic [16:0] cfg_length;
  logic        cfg_wide;
  logic [15:0] fp_words [0:WORDS-1];
  bit          written  [0:WORDS-1];

  answer_t answer_q [$];
  answer_t want;
  int      errors;
  int      cycles;
  int      items;
  bit      src_idle;
  bit      sink_idle;
  int      hold_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [63:0] mix_key(input logic [63:0] x, input logic [63:0] s);
    x = x ^ s;
    x = x ^ (x >> 33);
    x = x * HASH_MUL1;
    x = x ^ (x >> 29);
    x = x * HASH_MUL2;
    x = x ^ (x >> 32);
    return x;
  endfunction

  function automatic slots_t hash_slots(input logic [63:0] key);
    slots_t s;
    logic [63:0] h;
    logic [63:0] f;
    logic [63:0] seg;
    h = mix_key(key, cfg_seed);
    seg = ({32'd0, h[63:32]} * {51'd0, cfg_segments}) >> 32;
    s.i0 = seg * SEG_LEN + (h & SEG_MASK);
    s.i1 = (seg + 64'd1) * SEG_LEN + ((h >> 16) & SEG_MASK);
    s.i2 = (seg + 64'd2) * SEG_LEN + ((h >> 48) & SEG_MASK);
    f = mix_key(key, cfg_seed + FP_ADD);
    s.fp = cfg_wide ? f[63:48] : {8'h00, f[7:0]};
    return s;
  endfunction

  function automatic bit readable(input logic [63:0] idx);
    return (idx < {47'd0, cfg_length}) && (idx < WORDS);
  endfunction

  function automatic logic [15:0] word_at(input logic [63:0] idx);
    return readable(idx) ? fp_words[idx[15:0]] : 16'h0000;
  endfunction

  function automatic logic [15:0] slot_xor(input slots_t s);
    return word_at(s.i0) ^ word_at(s.i1) ^ word_at(s.i2);
  endfunction

  function automatic logic [15:0] fp_mask();
    return cfg_wide ? 16'hFFFF : 16'h00FF;
  endfunction

  function automatic logic membership(input logic [63:0] key);
    slots_t s;
    s = hash_slots(key);
    return ((slot_xor(s) ^ s.fp) & fp_mask()) == 16'h0000;
  endfunction

  // random key that touches at least one live slot, if one turns up quickly
  function automatic logic [63:0] live_key();
    logic [63:0] key;
    slots_t s;
    for (int t = 0; t < 8; t++) begin
      key = {$urandom, $urandom};
      s = hash_slots(key);
      if (readable(s.i0) || readable(s.i1) || readable(s.i2)) return key;
    end
    return key;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic exp);
    errors++;
    $display("mismatch %s: got %b expected %b (cycle %0d)", what, got, exp, cycles);
  endtask

  always @(posedge clk) begin
    if (!rst && rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
      if (answer_q.size() == 0) begin
        report_mismatch("response with no request", rsp.query_done, 1'b0);
      end else begin
        want = answer_q.pop_front();
        if (rsp.query_done !== want.query_done)
          report_mismatch("query_done", rsp.query_done, want.query_done);
        if (rsp.is_member !== want.is_member)
          report_mismatch("is_member", rsp.is_member, want.is_member);
      end
    end
  end

  // response side: random stalls, plus a long hold-off when a test sets hold_cycles
  initial begin
    int gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        rsp.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      gap = sink_idle ? $urandom_range(5) : 0;
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!(rsp.valid === 1'b1 && rsp.ready === 1'b1)) @(posedge clk);
    end
  end

  task automatic send_request(input logic op, input logic [63:0] key,
                              input logic [15:0] slot, input logic [15:0] value);
    int gap;
    answer_t a;
    gap = src_idle ? $urandom_range(5) : 0;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.opcode      <= op;
    req.key         <= key;
    req.slot        <= slot;
    req.entry_value <= value;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    items++;
    if (op == bffl_pkg::OP_WRITE) begin
      fp_words[slot] = value;
      written[slot] = 1'b1;
      a.is_member = 1'b0;
      a.query_done = 1'b0;
    end else begin
      a.is_member = membership(key);
      a.query_done = 1'b1;
    end
    answer_q.push_back(a);
  endtask

  task automatic send_write(input logic [15:0] slot, input logic [15:0] value);
    send_request(bffl_pkg::OP_WRITE, {$urandom, $urandom}, slot, value);
  endtask

  // give every live slot of the key a defined table word before it is read
  task automatic cover_slots(input logic [63:0] key);
    slots_t s;
    logic [63:0] idx [3];
    s = hash_slots(key);
    idx[0] = s.i0;
    idx[1] = s.i1;
    idx[2] = s.i2;
    for (int j = 0; j < 3; j++)
      if (readable(idx[j]) && !written[idx[j][15:0]])
        send_write(idx[j][15:0], 16'($urandom));
  endtask

  task automatic send_query(input logic [63:0] key);
    cover_slots(key);
    send_request(bffl_pkg::OP_QUERY, key, 16'($urandom), 16'($urandom));
  endtask

  // optionally patch one live slot so the query hits or misses by one bit
  task automatic probe_key(input logic [63:0] key, input fix_t how);
    slots_t s;
    logic [63:0] idx [3];
    logic [63:0] pick;
    logic [15:0] target;
    logic [15:0] patched;
    int live [$];
    cover_slots(key);
    s = hash_slots(key);
    idx[0] = s.i0;
    idx[1] = s.i1;
    idx[2] = s.i2;
    for (int j = 0; j < 3; j++)
      if (readable(idx[j])) live.push_back(j);
    if (how != FIX_NONE && live.size() > 0) begin
      pick = idx[live[$urandom_range(live.size() - 1)]];
      target = s.fp;
      if (how == FIX_NEAR)
        target = target ^ (16'd1 << $urandom_range(cfg_wide ? 15 : 7));
      patched = fp_words[pick[15:0]] ^ ((slot_xor(s) ^ target) & fp_mask());
      if (!cfg_wide) patched[15:8] = 8'($urandom);
      send_write(pick[15:0], patched);
    end
    send_query(key);
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [63:0] value);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    case (index)
      bffl_pkg::REG_SEED: begin
        cfg_seed = value;
      end
      bffl_pkg::REG_SEG_TOTAL: begin
        cfg_segments = value[12:0];
        value = {junk[50:0], value[12:0]};
      end
      bffl_pkg::REG_TABLE_LEN: begin
        cfg_length = value[16:0];
        value = {junk[46:0], value[16:0]};
      end
      bffl_pkg::REG_WIDE_FP: begin
        cfg_wide = value[0];
        value = {junk[62:0], value[0]};
      end
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic reconfigure(input logic [63:0] seed, input logic [12:0] segs,
                             input logic [16:0] len, input logic wide);
    drain();
    write_reg(bffl_pkg::REG_SEED, seed);
    write_reg(bffl_pkg::REG_SEG_TOTAL, {51'd0, segs});
    write_reg(bffl_pkg::REG_TABLE_LEN, {47'd0, len});
    write_reg(bffl_pkg::REG_WIDE_FP, {63'd0, wide});
  endtask

  // reset values: no live slots, so only the fingerprint decides
  task automatic test_reset_defaults();
    send_query(64'h0);
    send_query(64'hFFFF_FFFF_FFFF_FFFF);
    send_query({$urandom, $urandom});
  endtask

  task automatic test_write_ack();
    send_write(16'h0000, 16'hFFFF);
    send_write(16'hFFFF, 16'h0000);
    send_write(16'h5555, 16'hAAAA);
  endtask

  // back-to-back stretch over the low table words
  task automatic test_fill_table();
    src_idle = 1'b0;
    sink_idle = 1'b0;
    for (int s = 0; s < 64; s++)
      send_write(16'(s), 16'($urandom));
    drain();
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  task automatic test_narrow_mode();
    reconfigure(64'hFFFF_FFFF_FFFF_FFFF, 13'd3, 17'd40, 1'b0);
    probe_key(live_key(), FIX_HIT);
    probe_key(live_key(), FIX_HIT);
    probe_key(live_key(), FIX_NEAR);
    probe_key(live_key(), FIX_NONE);
  endtask

  task automatic test_wide_mode();
    reconfigure({$urandom, $urandom}, 13'd100, 17'd65536, 1'b1);
    probe_key(live_key(), FIX_HIT);
    probe_key(live_key(), FIX_NEAR);
    probe_key(live_key(), FIX_NONE);
  endtask

  task automatic test_slot_limits();
    reconfigure(64'h0, 13'd3, 17'd20, 1'b0);
    probe_key(live_key(), FIX_HIT);
    probe_key(live_key(), FIX_NONE);
    reconfigure(64'h0, 13'd3, 17'd0, 1'b1);
    send_query({$urandom, $urandom});
  endtask

  task automatic test_segment_extremes();
    reconfigure({$urandom, $urandom}, 13'd0, 17'd24, 1'b0);
    probe_key(live_key(), FIX_HIT);
    reconfigure({$urandom, $urandom}, 13'd8191, 17'd131071, 1'b1);
    probe_key(live_key(), FIX_HIT);
    send_query({$urandom, $urandom});
    reconfigure({$urandom, $urandom}, 13'd8190, 17'd65536, 1'b0);
    probe_key(live_key(), FIX_HIT);
  endtask

  task automatic test_backpressure();
    reconfigure({$urandom, $urandom}, 13'd50, 17'd416, 1'b0);
    hold_cycles = 400;
    for (int n = 0; n < 60; n++)
      probe_key(live_key(), ($urandom_range(1) != 0) ? FIX_HIT : FIX_NONE);
    // sender waits for every answer, then resumes on the same settings
    req.valid <= 1'b0;
    while (answer_q.size() != 0) @(posedge clk);
    for (int n = 0; n < 20; n++)
      probe_key(live_key(), FIX_HIT);
  endtask

  task automatic test_random_mix();
    logic [12:0] segs;
    logic [16:0] len;
    logic [63:0] seed;
    logic [63:0] key;
    int start;
    int r;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(5))
        0: segs = 13'($urandom_range(2));
        1: segs = 13'd3;
        2: segs = 13'd8190;
        3: segs = 13'd8191;
        default: segs = 13'($urandom_range(3, 8190));
      endcase
      case ($urandom_range(6))
        0: len = 17'd0;
        1: len = 17'd65536;
        2: len = 17'd131071;
        3: len = 17'($urandom_range(131071));
        default: len = ((segs + 32'd2) * 8 > 131071) ? 17'd131071 : 17'((segs + 32'd2) * 8);
      endcase
      case ($urandom_range(3))
        0: seed = 64'h0;
        1: seed = 64'hFFFF_FFFF_FFFF_FFFF;
        default: seed = {$urandom, $urandom};
      endcase
      if (phase == 0) begin
        segs = 13'd8190;
        len = 17'd65536;
      end
      reconfigure(seed, segs, len, 1'($urandom_range(1)));
      src_idle = (phase % 4) != 3;
      sink_idle = (phase % 4) != 3;
      start = items;
      while (items - start < 80) begin
        r = $urandom_range(99);
        if (r < 70) begin
          probe_key(live_key(), (r < 45) ? FIX_HIT : (r < 60) ? FIX_NEAR : FIX_NONE);
        end else if (r < 85) begin
          send_write(16'($urandom), 16'($urandom));
        end else begin
          case (r % 5)
            0: key = 64'h0;
            1: key = 64'hFFFF_FFFF_FFFF_FFFF;
            default: key = {$urandom, $urandom};
          endcase
          send_query(key);
        end
      end
    end
    src_idle = 1'b1;
    sink_idle = 1'b1;
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= bffl_pkg::REG_SEED;
    cfg_data        <= 64'h0;
    req.valid       <= 1'b0;
    req.opcode      <= bffl_pkg::OP_QUERY;
    req.key         <= 64'h0;
    req.slot        <= 16'h0;
    req.entry_value <= 16'h0;
    errors       = 0;
    items        = 0;
    hold_cycles  = 0;
    src_idle     = 1'b1;
    sink_idle    = 1'b1;
    cfg_seed     = 64'h0;
    cfg_segments = 13'd3;
    cfg_length   = 17'd0;
    cfg_wide     = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_write_ack();
    test_fill_table();
    test_narrow_mode();
    test_wide_mode();
    test_slot_limits();
    test_segment_extremes();
    test_backpressure();
    test_random_mix();

    drain();
    repeat (30) @(posedge clk);
    if (errors == 0 && answer_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
`default_nettype wire
